[sv/awbsp_pkg.sv]
// Shared types and constants of the statistics buffer parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package awbsp_pkg;

    // field widths
    localparam int WORD_W    = 16;
    localparam int IDX_W     = 13;
    localparam int LUMA_W    = 8;
    localparam int PAX_CNT_W = 14;
    localparam int BUF_W     = 17;
    localparam int LIMIT_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;

    // paxel layout
    localparam int GROUP_SIZE   = 8;
    localparam int GRP_W        = $clog2(GROUP_SIZE);
    localparam int SKIP_W       = $clog2(GROUP_SIZE + 1);
    localparam int REC_WORDS    = 8;
    localparam int WIR_W        = $clog2(REC_WORDS);
    localparam int DEFAULT_MAX_PAXELS = 8192;

    // word slots inside one paxel record
    localparam logic [WIR_W-1:0] WORD_GR   = WIR_W'(0);
    localparam logic [WIR_W-1:0] WORD_R    = WIR_W'(1);
    localparam logic [WIR_W-1:0] WORD_B    = WIR_W'(2);
    localparam logic [WIR_W-1:0] WORD_GB   = WIR_W'(3);
    localparam logic [WIR_W-1:0] WORD_LAST = WIR_W'(REC_WORDS - 1);

    // saturating word position
    localparam logic [BUF_W-1:0] POS_MAX = {BUF_W{1'b1}};

    // luma weights and divide-by-1000 reciprocal
    localparam int W_R          = 299;
    localparam int W_G          = 587;
    localparam int W_B          = 114;
    localparam int LUMA_DIV     = 1000;
    localparam int LUMA_MAX     = 255;
    localparam int SAT_THRESH   = (LUMA_MAX + 1) * LUMA_DIV;
    localparam int RECIP_SHIFT  = 28;
    localparam int RECIP        = 268436;
    localparam int PROD_R_W     = 25;
    localparam int PROD_G_W     = 27;
    localparam int PROD_B_W     = 23;
    localparam int TOTAL_W      = 26;
    localparam int DIVIN_W      = 18;
    localparam int RECIP_W      = 19;
    localparam int QPROD_W      = DIVIN_W + RECIP_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAXEL_COUNT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_WORDS = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LIMIT = CFG_IDX_W'(2);

    localparam logic [PAX_CNT_W-1:0] RST_PAXEL_COUNT  = PAX_CNT_W'(7224);
    localparam logic [BUF_W-1:0]     RST_BUFFER_WORDS = BUF_W'(65016);
    localparam logic [LIMIT_W-1:0]   RST_REPEAT_LIMIT = LIMIT_W'(100);

    // result kinds
    localparam logic KIND_PAXEL   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [PAX_CNT_W-1:0] pax_target;
        logic [BUF_W-1:0]     buffer_words;
        logic [LIMIT_W-1:0]   repeat_limit;
    } t_cfg;

    // everything one statistics word produces
    typedef struct packed {
        logic              pax_vld;
        logic              sum_vld;
        logic [IDX_W-1:0]  pax_idx;
        logic [WORD_W-1:0] sum_gr;
        logic [WORD_W-1:0] sum_r;
        logic [WORD_W-1:0] sum_b;
        logic [WORD_W-1:0] sum_gb;
        logic [IDX_W-1:0]  sum_idx;
        logic [WORD_W-1:0] checksum;
        logic              stuck;
    } t_bundle;

endpackage

`default_nettype wire

[sv/awbsp_parser.sv]
// Word-by-word parser of the statistics buffer: record walk, checksum, stuck detection.
// Depends on awbsp_pkg; feeds one registered bundle per word that yields results.
`default_nettype none

module awbsp_parser #(
    parameter int MAX_PAXELS = awbsp_pkg::DEFAULT_MAX_PAXELS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire awbsp_pkg::t_cfg               i_cfg,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [awbsp_pkg::WORD_W-1:0]  i_stat_word,
    input  wire logic                          i_buffer_end,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output awbsp_pkg::t_bundle                 o_bundle
);
    import awbsp_pkg::*;

    localparam int CW = $clog2(MAX_PAXELS + 1);
    localparam int WW = (CW > PAX_CNT_W) ? CW : PAX_CNT_W;

    // frame state
    logic [WIR_W-1:0]   r_wir,  n_wir;
    logic [GRP_W-1:0]   r_grp,  n_grp;
    logic [SKIP_W-1:0]  r_skip, n_skip;
    logic [CW-1:0]      r_cnt,  n_cnt;
    logic [BUF_W-1:0]   r_pos,  n_pos;
    logic               r_done, n_done;
    logic [WORD_W-1:0]  r_held_gr, r_held_r, r_held_b;
    logic [WORD_W-1:0]  r_cs,   n_cs;
    logic [WORD_W-1:0]  r_prev, n_prev;
    logic [LIMIT_W-1:0] r_rc,   n_rc;

    // output stage
    logic     r_vld;
    t_bundle  r_b, n_b;

    logic accept;
    logic stage_free;
    logic stop;

    assign stage_free = !r_vld || i_ready;
    assign o_ready    = stage_free;
    assign accept     = i_valid && stage_free;
    assign o_valid    = r_vld;
    assign o_bundle   = r_b;

    // next frame state and result bundle for the current word
    always_comb begin
        logic [WW-1:0]      eff;
        logic [WW-1:0]      cnt_ext;
        logic [WW-1:0]      cnt_new;
        logic [BUF_W:0]     pos_end;
        logic [SKIP_W:0]    grp_inc;
        logic [LIMIT_W-1:0] lim;
        logic [LIMIT_W-1:0] rc_inc;
        logic [WW-1:0]      last_idx;

        n_wir  = r_wir;
        n_grp  = r_grp;
        n_skip = r_skip;
        n_cnt  = r_cnt;
        n_pos  = r_pos;
        n_done = r_done;
        n_cs   = r_cs;
        n_prev = r_prev;
        n_rc   = r_rc;

        eff = (WW'(i_cfg.pax_target) < WW'(MAX_PAXELS)) ? WW'(i_cfg.pax_target)
                                                         : WW'(MAX_PAXELS);
        cnt_ext = WW'(r_cnt);
        pos_end = {1'b0, r_pos} + (BUF_W + 1)'(REC_WORDS);
        stop    = (r_wir == WORD_GR) &&
                  ((pos_end >= {1'b0, i_cfg.buffer_words}) || (cnt_ext >= eff));
        grp_inc = (SKIP_W + 1)'(r_grp) + (SKIP_W + 1)'(1);
        lim     = (i_cfg.repeat_limit == '0) ? LIMIT_W'(1) : i_cfg.repeat_limit;
        rc_inc  = r_rc + LIMIT_W'(1);

        n_b          = '0;
        n_b.sum_gr   = r_held_gr;
        n_b.sum_r    = r_held_r;
        n_b.sum_b    = r_held_b;
        n_b.sum_gb   = i_stat_word;
        n_b.pax_idx  = IDX_W'(cnt_ext);

        // record walk
        if (!r_done) begin
            if (r_skip != '0) begin
                n_skip = r_skip - SKIP_W'(1);
            end else if (stop) begin
                n_done = 1'b1;
            end else begin
                if (r_wir <= WORD_GB) begin
                    n_cs = r_cs + i_stat_word;
                end
                if (r_wir == WORD_GB) begin
                    n_b.pax_vld = 1'b1;
                    n_cnt       = r_cnt + CW'(1);
                end
                if (r_wir == WORD_LAST) begin
                    n_wir = '0;
                    if ((grp_inc >= (SKIP_W + 1)'(GROUP_SIZE)) || (WW'(n_cnt) >= eff)) begin
                        n_skip = SKIP_W'(grp_inc);
                        n_grp  = '0;
                    end else begin
                        n_grp  = GRP_W'(grp_inc);
                    end
                end else begin
                    n_wir = r_wir + WIR_W'(1);
                end
            end
        end

        // saturating position
        if (r_pos != POS_MAX) begin
            n_pos = r_pos + BUF_W'(1);
        end

        cnt_new  = WW'(n_cnt);
        last_idx = (cnt_new == '0) ? '0 : cnt_new - WW'(1);

        // frame summary and stuck check
        if (i_buffer_end) begin
            n_b.sum_vld  = 1'b1;
            n_b.sum_idx  = IDX_W'(last_idx);
            n_b.checksum = n_cs;
            if ((n_cs == r_prev) && (n_cs != '0)) begin
                if (rc_inc >= lim) begin
                    n_rc      = '0;
                    n_b.stuck = 1'b1;
                end else begin
                    n_rc      = rc_inc;
                end
            end else begin
                n_prev = n_cs;
                n_rc   = '0;
            end
            n_wir  = '0;
            n_grp  = '0;
            n_skip = '0;
            n_cnt  = '0;
            n_pos  = '0;
            n_done = 1'b0;
            n_cs   = '0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wir  <= '0;
            r_grp  <= '0;
            r_skip <= '0;
            r_cnt  <= '0;
            r_pos  <= '0;
            r_done <= 1'b0;
            r_cs   <= '0;
            r_prev <= '0;
            r_rc   <= '0;
            r_vld  <= 1'b0;
        end else begin
            if (accept) begin
                r_wir  <= n_wir;
                r_grp  <= n_grp;
                r_skip <= n_skip;
                r_cnt  <= n_cnt;
                r_pos  <= n_pos;
                r_done <= n_done;
                r_cs   <= n_cs;
                r_prev <= n_prev;
                r_rc   <= n_rc;
            end
            if (stage_free) begin
                r_vld <= accept && (n_b.pax_vld || n_b.sum_vld);
            end
        end
    end

    // held colour sums and result bundle
    always_ff @(posedge i_clk) begin
        if (accept && !r_done && (r_skip == '0) && !stop) begin
            case (r_wir)
                WORD_GR: r_held_gr <= i_stat_word;
                WORD_R:  r_held_r  <= i_stat_word;
                WORD_B:  r_held_b  <= i_stat_word;
                default: ;
            endcase
        end
        if (stage_free) begin
            r_b <= n_b;
        end
    end

    // checks
    a_skip_at_record_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skip != '0) |-> (r_wir == WORD_GR))
        else $error("count skip outside a record boundary");

    a_done_at_record_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_wir == WORD_GR))
        else $error("parsing stopped inside a record");

    a_gb_gives_paxel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_done && (r_skip == '0) && (r_wir == WORD_GB))
        |=> (r_vld && r_b.pax_vld))
        else $error("Gb word did not yield a paxel result");

endmodule

`default_nettype wire

[sv/awbsp_luma.sv]
// Three-stage luma pipeline: weighted products, sum and saturation, divide by 1000.
// Depends on awbsp_pkg; carries the parser bundle alongside the luma value.
`default_nettype none

module awbsp_luma (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire awbsp_pkg::t_bundle            i_bundle,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output awbsp_pkg::t_bundle                 o_bundle,
    output logic [awbsp_pkg::LUMA_W-1:0]       o_luma
);
    import awbsp_pkg::*;

    logic en1, en2, en3;
    logic r_vld1, r_vld2, r_vld3;
    t_bundle r_b1, r_b2, r_b3;

    logic [PROD_R_W-1:0] r_pr;
    logic [TOTAL_W-1:0]  r_pg;
    logic [PROD_B_W-1:0] r_pb;
    logic [DIVIN_W-1:0]  r_x;
    logic                r_sat;
    logic [LUMA_W-1:0]   r_luma;

    logic [PROD_R_W-1:0] w_pr;
    logic [PROD_G_W-1:0] w_pg;
    logic [PROD_B_W-1:0] w_pb;
    logic [TOTAL_W-1:0]  w_total;
    logic [QPROD_W-1:0]  w_q;

    // stage handshake
    assign en3     = !r_vld3 || i_ready;
    assign en2     = !r_vld2 || en3;
    assign en1     = !r_vld1 || en2;
    assign o_ready = en1;
    assign o_valid  = r_vld3;
    assign o_bundle = r_b3;
    assign o_luma   = r_luma;

    // weighted products, green pair halved
    assign w_pr = PROD_R_W'(i_bundle.sum_r) * PROD_R_W'(W_R);
    assign w_pg = PROD_G_W'({1'b0, i_bundle.sum_gr} + {1'b0, i_bundle.sum_gb}) * PROD_G_W'(W_G);
    assign w_pb = PROD_B_W'(i_bundle.sum_b) * PROD_B_W'(W_B);

    // weighted sum
    assign w_total = TOTAL_W'(r_pr) + r_pg + TOTAL_W'(r_pb);

    // divide by 1000 through the reciprocal, exact below the saturation point
    assign w_q = QPROD_W'(r_x) * QPROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (en1) r_vld1 <= i_valid;
            if (en2) r_vld2 <= r_vld1;
            if (en3) r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_b1 <= i_bundle;
            r_pr <= w_pr;
            r_pg <= w_pg[PROD_G_W-1:1];
            r_pb <= w_pb;
        end
        if (en2) begin
            r_b2  <= r_b1;
            r_x   <= w_total[DIVIN_W-1:0];
            r_sat <= (w_total >= TOTAL_W'(SAT_THRESH));
        end
        if (en3) begin
            r_b3   <= r_b2;
            r_luma <= r_sat ? LUMA_W'(LUMA_MAX) : w_q[RECIP_SHIFT+LUMA_W-1:RECIP_SHIFT];
        end
    end

endmodule

`default_nettype wire

[sv/awbsp_out.sv]
// Output register that unpacks a bundle into one or two results.
// Depends on awbsp_pkg; paxel result first, frame summary second.
`default_nettype none

module awbsp_out (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire awbsp_pkg::t_bundle            i_bundle,
    input  wire logic [awbsp_pkg::LUMA_W-1:0]  i_luma,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_kind,
    output logic [awbsp_pkg::IDX_W-1:0]        o_paxel_index,
    output logic [awbsp_pkg::WORD_W-1:0]       o_sum_gr,
    output logic [awbsp_pkg::WORD_W-1:0]       o_sum_r,
    output logic [awbsp_pkg::WORD_W-1:0]       o_sum_b,
    output logic [awbsp_pkg::WORD_W-1:0]       o_sum_gb,
    output logic [awbsp_pkg::LUMA_W-1:0]       o_luma,
    output logic [awbsp_pkg::WORD_W-1:0]       o_frame_checksum,
    output logic                               o_engine_stuck,
    output logic                               o_last
);
    import awbsp_pkg::*;

    logic              r_vld;
    logic              r_second;
    t_bundle           r_b;
    logic [LUMA_W-1:0] r_luma;
    logic              show_pax;

    // paxel result shown unless it has gone already
    assign show_pax    = r_b.pax_vld && !r_second;
    assign o_out_valid = r_vld;
    assign o_last      = show_pax ? !r_b.sum_vld : 1'b1;
    assign o_ready     = !r_vld || (i_out_ready && o_last);

    // result fields
    always_comb begin
        o_kind           = show_pax ? KIND_PAXEL : KIND_SUMMARY;
        o_paxel_index    = show_pax ? r_b.pax_idx : r_b.sum_idx;
        o_sum_gr         = show_pax ? r_b.sum_gr : '0;
        o_sum_r          = show_pax ? r_b.sum_r  : '0;
        o_sum_b          = show_pax ? r_b.sum_b  : '0;
        o_sum_gb         = show_pax ? r_b.sum_gb : '0;
        o_luma           = show_pax ? r_luma     : '0;
        o_frame_checksum = show_pax ? '0 : r_b.checksum;
        o_engine_stuck   = show_pax ? 1'b0 : r_b.stuck;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_second <= 1'b0;
        end else if (o_ready) begin
            r_vld    <= i_valid;
            r_second <= 1'b0;
        end else if (r_vld && i_out_ready) begin
            r_second <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_b    <= i_bundle;
            r_luma <= i_luma;
        end
    end

    // checks
    a_summary_follows_paxel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |=> (o_out_valid && (o_kind == KIND_SUMMARY)))
        else $error("paxel result not followed by its frame summary");

    a_paxel_fields_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_PAXEL)) |-> ((o_frame_checksum == '0) && !o_engine_stuck))
        else $error("paxel result carries summary fields");

endmodule

`default_nettype wire

[sv/awb_stats_buffer_parser.sv]
// Top level of the statistics buffer parser: configuration registers and the pipeline.
// Depends on awbsp_pkg, awbsp_parser, awbsp_luma and awbsp_out.
`default_nettype none

// The block takes one 16-bit statistics word per clock on the input request channel
// while o_in_ready is high and walks the paxel records (four colour sums, four skipped
// saturation words, count words after each group of up to eight paxels). Every Gb word
// yields a paxel result with its four sums and luma; the word flagged buffer_end yields a
// frame summary with the checksum and stuck flag, after the paxel result when both fall
// on the same word. Each word's results pass five registers on their way to the outputs
// (parser register, three luma stages, output register). The output register delivers
// one result per clock while the output is ready, so a word that yields two results
// holds the output until both have been taken. Words that yield no result take no
// pipeline slot; while results wait, words are still taken until the five stages are
// full, and then the input is held off. The configuration port is always ready and should
// only be written while the block is idle.

module awb_stats_buffer_parser #(
    parameter int MAX_PAXELS = awbsp_pkg::DEFAULT_MAX_PAXELS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [awbsp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [awbsp_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    // statistics words
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [awbsp_pkg::WORD_W-1:0]     i_stat_word,
    input  wire logic                             i_buffer_end,
    // results
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_kind,
    output logic [awbsp_pkg::IDX_W-1:0]           o_paxel_index,
    output logic [awbsp_pkg::WORD_W-1:0]          o_sum_gr,
    output logic [awbsp_pkg::WORD_W-1:0]          o_sum_r,
    output logic [awbsp_pkg::WORD_W-1:0]          o_sum_b,
    output logic [awbsp_pkg::WORD_W-1:0]          o_sum_gb,
    output logic [awbsp_pkg::LUMA_W-1:0]          o_luma,
    output logic [awbsp_pkg::WORD_W-1:0]          o_frame_checksum,
    output logic                                  o_engine_stuck,
    output logic                                  o_last
);
    import awbsp_pkg::*;

    t_cfg r_cfg;

    logic              prs_valid, prs_ready;
    t_bundle           prs_bundle;
    logic              lum_valid, lum_ready;
    t_bundle           lum_bundle;
    logic [LUMA_W-1:0] lum_luma;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pax_target   <= RST_PAXEL_COUNT;
            r_cfg.buffer_words <= RST_BUFFER_WORDS;
            r_cfg.repeat_limit <= RST_REPEAT_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PAXEL_COUNT:  r_cfg.pax_target   <= i_cfg_data[PAX_CNT_W-1:0];
                CFG_BUFFER_WORDS: r_cfg.buffer_words <= i_cfg_data[BUF_W-1:0];
                CFG_REPEAT_LIMIT: r_cfg.repeat_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    awbsp_parser #(
        .MAX_PAXELS (MAX_PAXELS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_stat_word  (i_stat_word),
        .i_buffer_end (i_buffer_end),
        .o_valid      (prs_valid),
        .i_ready      (prs_ready),
        .o_bundle     (prs_bundle)
    );

    awbsp_luma u_luma (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (prs_valid),
        .o_ready  (prs_ready),
        .i_bundle (prs_bundle),
        .o_valid  (lum_valid),
        .i_ready  (lum_ready),
        .o_bundle (lum_bundle),
        .o_luma   (lum_luma)
    );

    awbsp_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (lum_valid),
        .o_ready          (lum_ready),
        .i_bundle         (lum_bundle),
        .i_luma           (lum_luma),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_paxel_index    (o_paxel_index),
        .o_sum_gr         (o_sum_gr),
        .o_sum_r          (o_sum_r),
        .o_sum_b          (o_sum_b),
        .o_sum_gb         (o_sum_gb),
        .o_luma           (o_luma),
        .o_frame_checksum (o_frame_checksum),
        .o_engine_stuck   (o_engine_stuck),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench of the statistics buffer parser: directed and random frames,
// every result predicted by a scoreboard class and checked in order.
// Depends on awbsp_pkg and awb_stats_buffer_parser.

module testbench;
    import awbsp_pkg::*;

    localparam int CLK_HALF          = 10;
    localparam int RST_CYCLES        = 7;
    // random part with its worst idling on both sides, taken several times over
    localparam int CYCLE_LIMIT       = 500_000;
    // pipeline is five deep, leave some margin before touching the registers
    localparam int DRAIN_CYCLES      = 12;
    localparam int RANDOM_WORDS      = 1000;
    localparam int MAX_REPORTS       = 10;
    localparam int FRAME_CAP         = 220;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  paxel_index;
        logic [WORD_W-1:0] sum_gr;
        logic [WORD_W-1:0] sum_r;
        logic [WORD_W-1:0] sum_b;
        logic [WORD_W-1:0] sum_gb;
        logic [LUMA_W-1:0] luma;
        logic [WORD_W-1:0] checksum;
        logic              stuck;
        logic              last;
    } t_parser_result;

    // predicts paxel results and frame summaries, holds them until they are checked
    class stats_scoreboard;
        logic [PAX_CNT_W-1:0] pax_target;
        logic [BUF_W-1:0]     buffer_words;
        logic [LIMIT_W-1:0]   repeat_limit;
        int                   rec_word;
        int                   group_paxels;
        int                   count_skip;
        int                   paxels_done;
        int                   position;
        bit                   stopped;
        logic [WORD_W-1:0]    held[3];
        logic [WORD_W-1:0]    checksum;
        logic [WORD_W-1:0]    prev_checksum;
        int                   repeats;
        t_parser_result       expected[$];
        int                   errors;

        function new();
            pax_target    = RST_PAXEL_COUNT;
            buffer_words  = RST_BUFFER_WORDS;
            repeat_limit  = RST_REPEAT_LIMIT;
            prev_checksum = '0;
            repeats       = 0;
            errors        = 0;
            start_frame();
        endfunction

        function void start_frame();
            rec_word     = 0;
            group_paxels = 0;
            count_skip   = 0;
            paxels_done  = 0;
            position     = 0;
            stopped      = 1'b0;
            held[0]      = '0;
            held[1]      = '0;
            held[2]      = '0;
            checksum     = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_PAXEL_COUNT:  pax_target   = data[PAX_CNT_W-1:0];
                CFG_BUFFER_WORDS: buffer_words = data[BUF_W-1:0];
                CFG_REPEAT_LIMIT: repeat_limit = data[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        // one accepted statistics word
        function void note_word(logic [WORD_W-1:0] w, logic buf_end);
            t_parser_result made[2];
            int n;
            int eff;
            int lim;
            int unsigned y;
            n   = 0;
            eff = (int'(pax_target) < DEFAULT_MAX_PAXELS) ? int'(pax_target)
                                                           : DEFAULT_MAX_PAXELS;
            if (!stopped) begin
                if (count_skip != 0) begin
                    count_skip--;
                end else begin
                    // stop check only at the head of a record
                    if (rec_word == 0 &&
                        (position + REC_WORDS >= int'(buffer_words) || paxels_done >= eff))
                        stopped = 1'b1;
                    if (!stopped) begin
                        if (rec_word < 4) begin
                            checksum = checksum + w;
                            if (rec_word < 3) begin
                                held[rec_word] = w;
                            end else begin
                                y = (W_R * int'(held[1]) + (W_G * (int'(held[0]) + int'(w))) / 2
                                     + W_B * int'(held[2])) / LUMA_DIV;
                                if (y > LUMA_MAX)
                                    y = LUMA_MAX;
                                made[n]             = '0;
                                made[n].kind        = KIND_PAXEL;
                                made[n].paxel_index = paxels_done[IDX_W-1:0];
                                made[n].sum_gr      = held[0];
                                made[n].sum_r       = held[1];
                                made[n].sum_b       = held[2];
                                made[n].sum_gb      = w;
                                made[n].luma        = y[LUMA_W-1:0];
                                n++;
                                paxels_done++;
                            end
                        end
                        // end of record, count words follow a full or final group
                        if (rec_word == REC_WORDS - 1) begin
                            rec_word = 0;
                            group_paxels++;
                            if (group_paxels >= GROUP_SIZE || paxels_done >= eff) begin
                                count_skip   = group_paxels;
                                group_paxels = 0;
                            end
                        end else begin
                            rec_word++;
                        end
                    end
                end
            end
            if (position < int'(POS_MAX))
                position++;
            // frame summary with stuck detection
            if (buf_end) begin
                made[n]          = '0;
                made[n].kind     = KIND_SUMMARY;
                lim = (repeat_limit == 0) ? 1 : int'(repeat_limit);
                if (checksum == prev_checksum && checksum != 0) begin
                    repeats++;
                    if (repeats >= lim) begin
                        repeats       = 0;
                        made[n].stuck = 1'b1;
                    end
                end else begin
                    prev_checksum = checksum;
                    repeats       = 0;
                end
                made[n].paxel_index = (paxels_done != 0) ? IDX_W'(paxels_done - 1) : '0;
                made[n].checksum    = checksum;
                n++;
                start_frame();
            end
            if (n > 0)
                made[n-1].last = 1'b1;
            for (int k = 0; k < n; k++)
                expected.push_back(made[k]);
        endfunction

        function string show(t_parser_result r);
            return $sformatf("kind=%0d idx=%0d gr=%h r=%h b=%h gb=%h luma=%0d cs=%h stuck=%0d last=%0d",
                             r.kind, r.paxel_index, r.sum_gr, r.sum_r, r.sum_b, r.sum_gb,
                             r.luma, r.checksum, r.stuck, r.last);
        endfunction

        function void check_result(t_parser_result got);
            t_parser_result want;
            if (expected.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: %s", show(got));
                return;
            end
            want = expected.pop_front();
            if (got.kind !== want.kind || got.paxel_index !== want.paxel_index ||
                got.sum_gr !== want.sum_gr || got.sum_r !== want.sum_r ||
                got.sum_b !== want.sum_b || got.sum_gb !== want.sum_gb ||
                got.luma !== want.luma || got.checksum !== want.checksum ||
                got.stuck !== want.stuck || got.last !== want.last) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("mismatch expected: %s", show(want));
                    $display("         actual:   %s", show(got));
                end
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [WORD_W-1:0]    i_stat_word;
    logic                 i_buffer_end;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_kind;
    logic [IDX_W-1:0]     o_paxel_index;
    logic [WORD_W-1:0]    o_sum_gr;
    logic [WORD_W-1:0]    o_sum_r;
    logic [WORD_W-1:0]    o_sum_b;
    logic [WORD_W-1:0]    o_sum_gb;
    logic [LUMA_W-1:0]    o_luma;
    logic [WORD_W-1:0]    o_frame_checksum;
    logic                 o_engine_stuck;
    logic                 o_last;

    stats_scoreboard      sb;
    t_parser_result       seen_result;
    logic [WORD_W-1:0]    frame_words[$];
    bit                   no_idle = 1'b0;
    int                   cycles = 0;

    awb_stats_buffer_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_stat_word      (i_stat_word),
        .i_buffer_end     (i_buffer_end),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_paxel_index    (o_paxel_index),
        .o_sum_gr         (o_sum_gr),
        .o_sum_r          (o_sum_r),
        .o_sum_b          (o_sum_b),
        .o_sum_gb         (o_sum_gb),
        .o_luma           (o_luma),
        .o_frame_checksum (o_frame_checksum),
        .o_engine_stuck   (o_engine_stuck),
        .o_last           (o_last)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_idle();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    // result side back-pressure
    initial begin
        int hold;
        int stall;
        forever begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
            i_out_ready <= 1'b1;
            repeat (hold) @(posedge i_clk);
            stall = pick_idle();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_result.kind        = o_kind;
            seen_result.paxel_index = o_paxel_index;
            seen_result.sum_gr      = o_sum_gr;
            seen_result.sum_r       = o_sum_r;
            seen_result.sum_b       = o_sum_b;
            seen_result.sum_gb      = o_sum_gb;
            seen_result.luma        = o_luma;
            seen_result.checksum    = o_frame_checksum;
            seen_result.stuck       = o_engine_stuck;
            seen_result.last        = o_last;
            sb.check_result(seen_result);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic program_regs(input logic [CFG_DAT_W-1:0] pc, input logic [CFG_DAT_W-1:0] bw,
                                input logic [CFG_DAT_W-1:0] rl, input bit spare);
        write_reg(CFG_PAXEL_COUNT, pc);
        write_reg(CFG_BUFFER_WORDS, bw);
        write_reg(CFG_REPEAT_LIMIT, rl);
        // the unused index must leave every register alone
        if (spare)
            write_reg(CFG_SPARE, CFG_DAT_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_word(input logic [WORD_W-1:0] w, input logic buf_end);
        int gap;
        i_in_valid   <= 1'b1;
        i_stat_word  <= w;
        i_buffer_end <= buf_end;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(w, buf_end);
        gap = pick_idle();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_frame();
        for (int k = 0; k < frame_words.size(); k++)
            send_word(frame_words[k], k == frame_words.size() - 1);
    endtask

    // drain everything in flight before the registers change
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // frame length mostly matched to the paxel count and buffer size
    task automatic build_frame();
        int eff;
        int fit;
        int len;
        eff = (int'(sb.pax_target) < DEFAULT_MAX_PAXELS) ? int'(sb.pax_target)
                                                          : DEFAULT_MAX_PAXELS;
        fit = (GROUP_SIZE + 1) * ((eff < 24) ? eff : 24) + $urandom_range(1, 3);
        if (fit > int'(sb.buffer_words) + 3)
            fit = int'(sb.buffer_words) + $urandom_range(1, 3);
        if (fit > FRAME_CAP)
            fit = FRAME_CAP;
        case ($urandom_range(0, 19))
            0, 1, 2:             len = $urandom_range(1, 60);
            3, 4, 5, 6, 7, 8:    len = $urandom_range(1, fit);
            default:             len = fit;
        endcase
        frame_words.delete();
        repeat (len) frame_words.push_back(pick_word());
    endtask

    task automatic directed_frames();
        program_regs(CFG_DAT_W'(1), CFG_DAT_W'(100), CFG_DAT_W'(1), 1'b0);
        // full-scale sums with saturated luma, one count word, then the end word
        frame_words = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h5A5A, 16'hA5A5};
        send_frame();
        // frame ending on the gb word, sent twice so the repeat flags a stuck engine
        frame_words = '{16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE};
        send_frame();
        send_frame();
        // frame cut short inside a record
        frame_words = '{16'h1234, 16'h0000, 16'h0FF0};
        send_frame();
        // buffer too small for a single record
        wait_idle();
        program_regs(CFG_DAT_W'(1), CFG_DAT_W'(5), CFG_DAT_W'(1), 1'b0);
        frame_words = '{16'hBEEF, 16'h4321};
        send_frame();
    endtask

    task automatic random_phases();
        int sent;
        int nframes;
        int lim;
        bit same;
        logic [CFG_DAT_W-1:0] pc;
        logic [CFG_DAT_W-1:0] bw;
        logic [CFG_DAT_W-1:0] rl;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            wait_idle();
            case ($urandom_range(0, 9))
                0:       pc = '0;
                1:       pc = CFG_DAT_W'($urandom_range(DEFAULT_MAX_PAXELS + 1, 16383));
                2:       pc = CFG_DAT_W'($urandom);
                default: pc = CFG_DAT_W'($urandom_range(1, 24));
            endcase
            case ($urandom_range(0, 9))
                0:       bw = CFG_DAT_W'($urandom_range(0, REC_WORDS - 1));
                1:       bw = '1;
                2:       bw = CFG_DAT_W'($urandom);
                default: bw = CFG_DAT_W'($urandom_range(REC_WORDS, 250));
            endcase
            case ($urandom_range(0, 9))
                0:       rl = '0;
                1:       rl = CFG_DAT_W'(255);
                2:       rl = CFG_DAT_W'($urandom);
                default: rl = CFG_DAT_W'($urandom_range(1, 4));
            endcase
            program_regs(pc, bw, rl, $urandom_range(0, 5) == 0);
            // identical frames in a row exercise the stuck detection
            lim     = (sb.repeat_limit == 0) ? 1 : int'(sb.repeat_limit);
            same    = $urandom_range(0, 1);
            nframes = same ? ((lim < 6) ? lim + 1 : 3) : $urandom_range(2, 5);
            build_frame();
            for (int f = 0; f < nframes; f++) begin
                if (f > 0 && !same && $urandom_range(0, 3) != 0)
                    build_frame();
                no_idle = ($urandom_range(0, 4) == 0);
                send_frame();
                sent += frame_words.size();
                if (sent >= RANDOM_WORDS)
                    break;
            end
        end
        no_idle = 1'b0;
    endtask

    // stimulus
    initial begin
        sb = new();
        i_rst_n      <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_stat_word  <= '0;
        i_buffer_end <= 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_frames();
        random_phases();
        wait_idle();
        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
